/* rtl/lru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lru_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int VALUE_BITS_DEF = 64;
  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {KIND_LOOKUP = 1'b0, KIND_STORE = 1'b1} kind_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [4:0]  fill_level;
  } rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_APPLY, ST_SEND} exec_state_t;
endpackage
`default_nettype wire

/* rtl/lru_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lru_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire lru_pkg::req_t in_data,
  output logic              q_valid,
  input  wire logic         q_pop,
  output lru_pkg::req_t     q_data
);
  import lru_pkg::*;
  // two-entry request queue
  req_t slot [2];
  logic [1:0] count;
  logic rd, wr;
  logic push, pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd <= 1'b0;
      wr <= 1'b0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr] <= in_data;
  end
endmodule
`default_nettype wire

/* rtl/lru_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lru_back #(
  parameter int ENTRIES = lru_pkg::ENTRIES_DEF,
  parameter int VALUE_BITS = lru_pkg::VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [4:0]    cfg_data,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire lru_pkg::req_t q_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lru_pkg::rsp_t      out_data
);
  import lru_pkg::*;
  localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RB = IB + 1;

  logic [63:0] kh [ENTRIES];
  logic [63:0] kl [ENTRIES];
  logic [VALUE_BITS-1:0] val [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [RB-1:0] rank [ENTRIES];
  logic [31:0] hits, misses;
  logic [CAP_BITS-1:0] used, cap_reg;
  logic [RB-1:0] cap;

  exec_state_t state, state_next;
  req_t req;
  logic [ENTRIES-1:0] match_r, free_r, lru_r;
  logic [ENTRIES-1:0] match_c, usable;
  rsp_t rsp;

  always_comb begin
    cap = (int'(cap_reg) > ENTRIES) ? RB'(ENTRIES) : RB'(cap_reg);
    for (int i = 0; i < ENTRIES; i++) begin
      usable[i] = (RB'(i) < cap);
      match_c[i] = usable[i] && vld[i] && kh[i] == req.key_high && kl[i] == req.key_low;
    end
  end

  // priority picks from registered match vectors
  logic found, got_free, got_lru;
  logic [IB-1:0] fidx, freeidx, lruidx;
  always_comb begin
    found = 1'b0; fidx = '0; got_free = 1'b0; freeidx = '0; got_lru = 1'b0; lruidx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin found = 1'b1; fidx = IB'(i); end
      if (free_r[i]) begin got_free = 1'b1; freeidx = IB'(i); end
      if (lru_r[i]) begin got_lru = 1'b1; lruidx = IB'(i); end
    end
  end

  // least recent is the valid usable slot with rank used-1
  logic is_store, full, do_fill, do_evict, do_touch;
  logic [IB-1:0] tgt;
  logic [RB-1:0] oldr;
  always_comb begin
    is_store = (req.kind == KIND_STORE);
    full = !(RB'(used) < cap);
    do_touch = found;
    do_fill = is_store && !found && !full && got_free;
    do_evict = is_store && !found && full && got_lru;
    tgt = found ? fidx : (do_fill ? freeidx : lruidx);
    oldr = rank[tgt];
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = ST_MATCH;
      end
      ST_MATCH: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_SEND;
      ST_SEND: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_SEND);
  assign out_data = rsp;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else if (cfg_we) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) req <= q_data;
    if (state == ST_MATCH) begin
      match_r <= match_c;
      for (int i = 0; i < ENTRIES; i++) begin
        free_r[i] <= usable[i] && !vld[i];
        lru_r[i] <= usable[i] && vld[i] && rank[i] == RB'(used) - RB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      vld <= '0;
      hits <= '0;
      misses <= '0;
      used <= '0;
      cap_reg <= rst ? CAP_RESET : cfg_data;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else if (state == ST_APPLY) begin
      rsp.hit <= 1'b0;
      rsp.value_out <= '0;
      rsp.evicted <= do_evict;
      if (cap != '0) begin
        if (!is_store) begin
          if (found) begin
            rsp.hit <= 1'b1;
            rsp.value_out <= 64'(val[fidx]);
            hits <= hits + 32'd1;
          end else misses <= misses + 32'd1;
        end else if (found) rsp.hit <= 1'b1;
        if (do_fill) used <= used + CAP_BITS'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (do_touch || do_fill || do_evict) begin
            if (IB'(i) == tgt) rank[i] <= '0;
            else if (vld[i] && (do_fill || rank[i] < oldr)) rank[i] <= rank[i] + RB'(1);
          end
        end
        if (do_fill || do_evict) vld[tgt] <= 1'b1;
      end
      rsp.hit_total <= hits + ((cap != '0 && !is_store && found) ? 32'd1 : 32'd0);
      rsp.miss_total <= misses + ((cap != '0 && !is_store && !found) ? 32'd1 : 32'd0);
      rsp.fill_level <= used + ((cap != '0 && do_fill) ? CAP_BITS'(1) : CAP_BITS'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPLY && cap != '0) begin
      if (do_fill || do_evict) begin
        kh[tgt] <= req.key_high;
        kl[tgt] <= req.key_low;
      end
      if (is_store && (found || do_fill || do_evict)) val[tgt] <= req.value_in[VALUE_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/lru_address_result_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// lru address result cache
// request channel in_valid/in_stall/in_data carries a lookup or store with a
// 128-bit key; response channel out_valid/out_stall/out_data returns one
// response per request in order.
// a two-entry request queue in front accepts requests while the execution
// sequencer works; for each request the sequencer steps through dequeue,
// match against all slots, apply update and present response, and it
// takes the next request only after the response has been taken; the
// response is registered in the apply step and held in the send step.
// cfg_we with cfg_data writes the capacity, empties the cache and clears the
// counters; write it only while idle.
// reset is synchronous: cache empty, counters zero, capacity 16.
// when out_stall is high the response holds; the queue keeps taking up to
// two more requests, then raises in_stall.
module lru_address_result_cache #(
  parameter int ENTRIES = lru_pkg::ENTRIES_DEF,
  parameter int VALUE_BITS = lru_pkg::VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [4:0]    cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lru_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lru_pkg::rsp_t      out_data
);
  import lru_pkg::*;
  logic q_valid, q_pop;
  req_t q_data;

  lru_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .q_valid, .q_pop, .q_data
  );

  lru_back #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

/* rtl/lru_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module lru_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire lru_pkg::rsp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response changed");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_data.fill_level <= 5'd16 || !out_valid)
    else $error("fill level above capacity");
  a_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.value_out == 64'd0)
    else $error("value on miss");
  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted |-> !out_data.hit)
    else $error("evict on hit");
endmodule

bind lru_address_result_cache lru_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .out_data
);
`default_nettype wire
